// ===== hw/rtl/vrq_pkg.sv =====
// Shared types and constants of the variable record ring queue.
`default_nettype none
package vrq_pkg;
   localparam int DEF_RING_WORDS = 512;
   localparam int OFF_W = 12;
   localparam int CAP_W = 13;
   localparam int WIDX_W = 9;
   localparam int WCNT_W = 10;
   localparam logic [CAP_W-1:0] HDR_BYTES = 13'd24;
   localparam logic [CAP_W-1:0] CAP_MIN = 13'd48;
   localparam int PAD_FLAG_BIT = 16;

   typedef enum logic [1:0] {
      CMD_PUSH_BEGIN = 2'd0,
      CMD_PUSH_DATA  = 2'd1,
      CMD_POP        = 2'd2,
      CMD_POP_DATA   = 2'd3
   } cmd_type;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NO_ROOM = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] out_type;
      logic [11:0] out_bytes;
      logic [63:0] out_word;
      logic        out_last;
   } result_type;
endpackage
`default_nettype wire

// ===== hw/rtl/vrq_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
`default_nettype none
module vrq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/vrq_ctrl.sv =====
// Sequencer that keeps the ring offsets and reads and writes the record memory.
`default_nettype none
module vrq_ctrl
   import vrq_pkg::*;
#(
   parameter int RING_WORDS = DEF_RING_WORDS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_accept,
   input  wire logic [1:0]                    req_cmd,
   input  wire logic [15:0]                   req_msg_type,
   input  wire logic [11:0]                   req_byte_count,
   input  wire logic [63:0]                   req_data_word,
   input  wire logic                          csr_write,
   input  wire logic [CAP_W-1:0]              csr_data,
   output logic                               idle,
   output logic                               mem_wr_en,
   output logic [$clog2(RING_WORDS)-1:0]      mem_wr_addr,
   output logic [63:0]                        mem_wr_data,
   output logic                               mem_rd_en,
   output logic [$clog2(RING_WORDS)-1:0]      mem_rd_addr,
   input  wire logic [63:0]                   mem_rd_data,
   output logic                               post_valid,
   input  wire logic                          post_ready,
   output result_type                         post_result
);
   localparam int AW = $clog2(RING_WORDS);
   localparam int CAP_MAX_I = (RING_WORDS * 8 < 4096) ? RING_WORDS * 8 : 4096;
   localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(CAP_MAX_I);

   typedef enum logic [3:0] {
      S_IDLE, S_BEGIN_CHK, S_BEGIN_PAD, S_BEGIN_HDR, S_DATA,
      S_POPD, S_POPD_CAP, S_POP, S_SCAN, S_EVAL, S_POST
   } state_type;

   state_type state_ff, state_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [OFF_W-1:0] head_ff, head_in, tail_ff, tail_in, commit_ff, commit_in;
   logic [CAP_W-1:0] fill_ff, fill_in;
   logic [WIDX_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [WCNT_W-1:0] wleft_ff, wleft_in, rleft_ff, rleft_in;
   logic [CAP_W-1:0] rd_len_ff, rd_len_in;
   logic [15:0] type_ff, type_in;
   logic [11:0] size_ff, size_in;
   logic [63:0] word_ff, word_in;
   logic [CAP_W:0] reserve_ff, reserve_in;
   logic [OFF_W-1:0] msg_ff, msg_in;
   result_type res_ff, res_in;

   logic drop_en;
   logic [CAP_W-1:0] drop_len;
   logic [CAP_W-1:0] needed, remaining, head_room, clamp_v, rec_len;
   logic [CAP_W:0] reserve_c;
   logic [CAP_W+1:0] fill_sum, tail_sum, head_sum;
   logic [WCNT_W-1:0] new_wleft;
   logic [OFF_W-1:0] new_tail;
   logic committed_zero;

   function automatic logic [WIDX_W-1:0] next3(input logic [WIDX_W-1:0] w,
                                               input logic [CAP_W-1:0] cap);
      logic [WCNT_W-1:0] s;
      s = {1'b0, w} + WCNT_W'(3);
      if (s >= cap[CAP_W-1:3]) begin
         s = s - cap[CAP_W-1:3];
      end
      return s[WIDX_W-1:0];
   endfunction

   function automatic logic [WIDX_W-1:0] next1(input logic [WIDX_W-1:0] w,
                                               input logic [CAP_W-1:0] cap);
      logic [WCNT_W-1:0] s;
      s = {1'b0, w} + WCNT_W'(1);
      if (s >= cap[CAP_W-1:3]) begin
         s = '0;
      end
      return s[WIDX_W-1:0];
   endfunction

   always_comb begin
      needed = (HDR_BYTES + CAP_W'(size_ff) + CAP_W'(7)) & ~CAP_W'(7);
      remaining = cap_ff - CAP_W'(tail_ff);
      head_room = cap_ff - CAP_W'(head_ff);
      rec_len = (HDR_BYTES + CAP_W'(mem_rd_data[43:32]) + CAP_W'(7)) & ~CAP_W'(7);
      reserve_c = (remaining < needed) ? {1'b0, needed} + {1'b0, remaining}
                                       : {1'b0, needed};
      fill_sum = {2'b0, fill_ff} + {1'b0, reserve_c};
      tail_sum = {3'b0, tail_ff} + {1'b0, reserve_ff};
      new_tail = (tail_sum >= {2'b0, cap_ff}) ? OFF_W'(tail_sum - {2'b0, cap_ff})
                                              : OFF_W'(tail_sum);
      new_wleft = WCNT_W'((CAP_W'(size_ff) + CAP_W'(7)) >> 3);
      committed_zero = (wleft_ff == '0) ? (fill_ff == '0) : (commit_ff == head_ff);
      clamp_v = csr_data & 13'h1FF8;
      if (clamp_v < CAP_MIN) begin
         clamp_v = CAP_MIN;
      end
      if (clamp_v > CAP_MAX) begin
         clamp_v = CAP_MAX;
      end
   end

   always_comb begin
      state_in = state_ff;
      cap_in = cap_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      commit_in = commit_ff;
      fill_in = fill_ff;
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      wleft_in = wleft_ff;
      rleft_in = rleft_ff;
      rd_len_in = rd_len_ff;
      type_in = type_ff;
      size_in = size_ff;
      word_in = word_ff;
      reserve_in = reserve_ff;
      msg_in = msg_ff;
      res_in = res_ff;
      drop_en = 1'b0;
      drop_len = '0;
      mem_wr_en = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      mem_rd_en = 1'b0;
      mem_rd_addr = '0;
      head_sum = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (csr_write) begin
               cap_in = clamp_v;
               head_in = '0;
               tail_in = '0;
               commit_in = '0;
               fill_in = '0;
               wptr_in = '0;
               rptr_in = '0;
               wleft_in = '0;
               rleft_in = '0;
            end else if (req_accept) begin
               type_in = req_msg_type;
               size_in = req_byte_count;
               word_in = req_data_word;
               res_in = '0;
               unique case (cmd_type'(req_cmd))
                  CMD_PUSH_BEGIN: state_in = S_BEGIN_CHK;
                  CMD_PUSH_DATA: state_in = S_DATA;
                  CMD_POP: state_in = S_POP;
                  CMD_POP_DATA: state_in = S_POPD;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_BEGIN_CHK: begin
            if (wleft_ff != '0 || needed >= cap_ff ||
                fill_sum > {2'b0, cap_ff}) begin
               res_in.status = ST_NO_ROOM;
               state_in = S_POST;
            end else begin
               reserve_in = reserve_c;
               msg_in = (remaining < needed) ? '0 : tail_ff;
               state_in = ((remaining >= HDR_BYTES) && (remaining < needed)) ?
                          S_BEGIN_PAD : S_BEGIN_HDR;
            end
         end
         S_BEGIN_PAD: begin
            mem_wr_en = 1'b1;
            mem_wr_addr = AW'(tail_ff[OFF_W-1:3]);
            mem_wr_data = 64'd1 << PAD_FLAG_BIT;
            state_in = S_BEGIN_HDR;
         end
         S_BEGIN_HDR: begin
            mem_wr_en = 1'b1;
            mem_wr_addr = AW'(msg_ff[OFF_W-1:3]);
            mem_wr_data = {20'd0, size_ff, 16'd0, type_ff};
            wptr_in = next3(msg_ff[OFF_W-1:3], cap_ff);
            wleft_in = new_wleft;
            tail_in = new_tail;
            fill_in = fill_ff + reserve_ff[CAP_W-1:0];
            commit_in = (new_wleft == '0) ? new_tail : msg_ff;
            state_in = S_POST;
         end
         S_DATA: begin
            if (wleft_ff == '0) begin
               res_in.status = ST_EMPTY;
            end else begin
               mem_wr_en = 1'b1;
               mem_wr_addr = AW'(wptr_ff);
               mem_wr_data = word_ff;
               wptr_in = next1(wptr_ff, cap_ff);
               wleft_in = wleft_ff - WCNT_W'(1);
               if (wleft_ff == WCNT_W'(1)) begin
                  commit_in = tail_ff;
               end
            end
            state_in = S_POST;
         end
         S_POPD: begin
            if (rleft_ff == '0) begin
               res_in.status = ST_EMPTY;
               state_in = S_POST;
            end else begin
               mem_rd_en = 1'b1;
               mem_rd_addr = AW'(rptr_ff);
               rptr_in = next1(rptr_ff, cap_ff);
               rleft_in = rleft_ff - WCNT_W'(1);
               if (rleft_ff == WCNT_W'(1)) begin
                  res_in.out_last = 1'b1;
                  drop_en = 1'b1;
                  drop_len = rd_len_ff;
               end
               state_in = S_POPD_CAP;
            end
         end
         S_POPD_CAP: begin
            res_in.out_word = mem_rd_data;
            state_in = S_POST;
         end
         S_POP: begin
            if (rleft_ff != '0) begin
               drop_en = 1'b1;
               drop_len = rd_len_ff;
               rleft_in = '0;
            end
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (committed_zero) begin
               res_in.status = ST_EMPTY;
               state_in = S_POST;
            end else if (head_room < HDR_BYTES) begin
               drop_en = 1'b1;
               drop_len = head_room;
            end else begin
               mem_rd_en = 1'b1;
               mem_rd_addr = AW'(head_ff[OFF_W-1:3]);
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (mem_rd_data[PAD_FLAG_BIT]) begin
               drop_en = 1'b1;
               drop_len = head_room;
               state_in = S_SCAN;
            end else if (mem_rd_data[15:0] != type_ff) begin
               drop_en = 1'b1;
               drop_len = rec_len;
               state_in = S_SCAN;
            end else begin
               res_in.out_type = mem_rd_data[15:0];
               res_in.out_bytes = mem_rd_data[43:32];
               if (mem_rd_data[43:32] == '0) begin
                  drop_en = 1'b1;
                  drop_len = rec_len;
               end else begin
                  rptr_in = next3(head_ff[OFF_W-1:3], cap_ff);
                  rleft_in = WCNT_W'((rec_len - HDR_BYTES) >> 3);
                  rd_len_in = rec_len;
               end
               state_in = S_POST;
            end
         end
         S_POST: begin
            if (post_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (drop_en) begin
         head_sum = {3'b0, head_ff} + {2'b0, drop_len};
         head_in = (head_sum >= {2'b0, cap_ff}) ? OFF_W'(head_sum - {2'b0, cap_ff})
                                                : OFF_W'(head_sum);
         fill_in = (fill_ff >= drop_len) ? fill_ff - drop_len : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cap_ff <= CAP_MAX;
         head_ff <= '0;
         tail_ff <= '0;
         commit_ff <= '0;
         fill_ff <= '0;
         wptr_ff <= '0;
         rptr_ff <= '0;
         wleft_ff <= '0;
         rleft_ff <= '0;
      end else begin
         state_ff <= state_in;
         cap_ff <= cap_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         commit_ff <= commit_in;
         fill_ff <= fill_in;
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         wleft_ff <= wleft_in;
         rleft_ff <= rleft_in;
      end
      rd_len_ff <= rd_len_in;
      type_ff <= type_in;
      size_ff <= size_in;
      word_ff <= word_in;
      reserve_ff <= reserve_in;
      msg_ff <= msg_in;
      res_ff <= res_in;
   end

   assign idle = (state_ff == S_IDLE);
   assign post_valid = (state_ff == S_POST);
   assign post_result = res_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/variable_record_ring_queue.sv =====
// Top level of the variable record ring queue with its result register.
//
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   cmd, msg_type, byte_count, data_word
// rsp       out        rsp_valid/rsp_stall   status, out_type, out_bytes, out_word, out_last
// csr       in         csr_valid/csr_ready   capacity_bytes
//
// One item is processed at a time, in the states of the shared sequencer. Push data writes one
// word if one is due; pop data reads one, if any is left, through the registered read port of
// the record memory; push begin checks for room, writes a padding header where one is needed,
// then the record header; pop drops any unread rest, then reads headers through the same port
// and skips gaps, padding and foreign records. A rejected push begin writes nothing.
// A synchronous reset empties the queue and sets the capacity to its maximum.
// A stalled result stays in the result register while the next item is taken.
`default_nettype none
module variable_record_ring_queue
   import vrq_pkg::*;
#(
   parameter int RING_WORDS = DEF_RING_WORDS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_cmd,
   input  wire logic [15:0]        req_msg_type,
   input  wire logic [11:0]        req_byte_count,
   input  wire logic signed [63:0] req_data_word,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [15:0]             rsp_out_type,
   output logic [11:0]             rsp_out_bytes,
   output logic signed [63:0]      rsp_out_word,
   output logic                    rsp_out_last,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [12:0]        csr_capacity_bytes
);
   localparam int AW = $clog2(RING_WORDS);

   logic idle, post_valid, post_ready, req_accept;
   logic mem_wr_en, mem_rd_en;
   logic [AW-1:0] mem_wr_addr, mem_rd_addr;
   logic [63:0] mem_wr_data, mem_rd_data;
   result_type post_result;
   logic rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   assign req_stall = !idle || csr_valid;
   assign csr_ready = idle;
   assign req_accept = req_valid && !req_stall;

   vrq_ctrl #(.RING_WORDS(RING_WORDS)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_accept(req_accept), .req_cmd(req_cmd), .req_msg_type(req_msg_type),
      .req_byte_count(req_byte_count), .req_data_word(req_data_word),
      .csr_write(csr_valid && csr_ready), .csr_data(csr_capacity_bytes),
      .idle(idle),
      .mem_wr_en(mem_wr_en), .mem_wr_addr(mem_wr_addr), .mem_wr_data(mem_wr_data),
      .mem_rd_en(mem_rd_en), .mem_rd_addr(mem_rd_addr), .mem_rd_data(mem_rd_data),
      .post_valid(post_valid), .post_ready(post_ready), .post_result(post_result)
   );

   vrq_ram #(.WIDTH(64), .DEPTH(RING_WORDS)) u_ram (
      .clock(clock),
      .wr_en(mem_wr_en), .wr_addr(mem_wr_addr), .wr_data(mem_wr_data),
      .rd_en(mem_rd_en), .rd_addr(mem_rd_addr), .rd_data(mem_rd_data)
   );

   assign post_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (post_valid && post_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in = post_result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_ff.status;
   assign rsp_out_type = rsp_ff.out_type;
   assign rsp_out_bytes = rsp_ff.out_bytes;
   assign rsp_out_word = rsp_ff.out_word;
   assign rsp_out_last = rsp_ff.out_last;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("input not stalled after a transfer");
   a_idle_not_posting: assert property (@(posedge clock) disable iff (reset)
      idle |-> !post_valid)
      else $error("result posted while idle");
   a_post_holds: assert property (@(posedge clock) disable iff (reset)
      post_valid && !post_ready |=> post_valid)
      else $error("pending result lost");
   a_post_once: assert property (@(posedge clock) disable iff (reset)
      post_valid && post_ready |=> !post_valid && rsp_valid)
      else $error("result posted twice or not registered");
endmodule
`default_nettype wire
